/* rtl/core/itf_pkg.sv */
`default_nettype none
package itf_pkg;

  localparam int MAX_WIDTH = 63;

  localparam int NDEC = 20;
  localparam int NHEX = 16;

  localparam logic [2:0] ACT_UDEC = 3'd0;
  localparam logic [2:0] ACT_SDEC = 3'd1;
  localparam logic [2:0] ACT_HEXL = 3'd2;
  localparam logic [2:0] ACT_HEXU = 3'd3;
  localparam logic [2:0] ACT_PTR  = 3'd4;
  localparam logic [2:0] ACT_CHAR = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  typedef struct packed {
    logic [5:0]  total;
    logic [5:0]  pad;
    logic [15:0] pre;
    logic [1:0]  pre_cnt;
    logic [7:0]  fill;
    logic        upper;
    logic [4*NDEC-1:0] digits;
  } itf_job_t;

  function automatic logic [7:0] dig2char(input logic [3:0] n, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (n < 4'd10) begin
      dig2char = CH_ZERO + {4'b0, n};
    end else begin
      dig2char = base + {4'b0, n} - 8'd10;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/itf_in_if.sv */
`default_nettype none
interface itf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] value;
  logic        is_long;
  logic [5:0]  field_width;
  logic        zero_fill;

  modport source (output valid, action, value, is_long, field_width, zero_fill,
                  input ready);
  modport sink (input valid, action, value, is_long, field_width, zero_fill,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/itf_out_if.sv */
`default_nettype none
interface itf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink (input valid, char_out, last, output ready);
endinterface
`default_nettype wire

/* rtl/core/integer_to_text_formatter_unit.sv */
`default_nettype none
// Formats one integer per input beat as ASCII text, one character per output beat,
// most significant first, with last set on the final character. Decimal kinds go
// through a bit-serial double-dabble converter, then a leading-zero strip
// of one digit a cycle (up to 19); hex kinds skip the double-dabble and strip up to
// 15 digits. Characters leave at one per cycle while the output is ready, and the
// next item is taken and converted while the previous text is still draining. A
// negative number is preceded by the padding, so zero fill gives text like 000-5.
// Kinds 6 and 7 are accepted and give no output.
module integer_to_text_formatter_unit
  import itf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  itf_in_if.sink    in_ch,
  itf_out_if.source out_ch
);

  logic        conv_idle, conv_done, take, job_ready, in_beat, act_ok;
  logic [63:0] ext, mag;
  logic        neg, is_dec;
  logic [4*NDEC-1:0] digits;
  logic [4:0]  ndig, ndig_eff;
  logic [5:0]  len, wsat;
  itf_job_t    job;

  logic [15:0] pre_r;
  logic [1:0]  pre_cnt_r;
  logic [7:0]  fill_r;
  logic        upper_r, is_char_r;
  logic [5:0]  width_r;

  assign in_ch.ready = conv_idle;
  assign in_beat     = in_ch.valid && conv_idle;
  assign act_ok      = (in_ch.action <= ACT_CHAR);

  always_comb begin
    ext = in_ch.value;
    if (!in_ch.is_long && in_ch.action != ACT_PTR) begin
      ext = (in_ch.action == ACT_SDEC) ? {{32{in_ch.value[31]}}, in_ch.value[31:0]}
                                       : {32'd0, in_ch.value[31:0]};
    end
    neg = (in_ch.action == ACT_SDEC) && ext[63];
    mag = neg ? (64'd0 - ext) : ext;
    if (in_ch.action == ACT_CHAR) begin
      mag = '0;
    end
    is_dec = (in_ch.action == ACT_UDEC) || (in_ch.action == ACT_SDEC);
  end

  always_ff @(posedge clk) begin
    if (in_beat && act_ok) begin
      upper_r   <= (in_ch.action == ACT_HEXU);
      is_char_r <= (in_ch.action == ACT_CHAR);
      fill_r    <= in_ch.zero_fill ? CH_ZERO : CH_SPACE;
      width_r   <= (int'(in_ch.field_width) > MAX_WIDTH) ? 6'(MAX_WIDTH)
                                                          : in_ch.field_width;
      if (in_ch.action == ACT_PTR) begin
        pre_r     <= {CH_ZERO, CH_X};
        pre_cnt_r <= 2'd2;
      end else if (in_ch.action == ACT_CHAR) begin
        pre_r     <= {in_ch.value[7:0], 8'd0};
        pre_cnt_r <= 2'd1;
      end else if (neg) begin
        pre_r     <= {CH_MINUS, 8'd0};
        pre_cnt_r <= 2'd1;
      end else begin
        pre_r     <= '0;
        pre_cnt_r <= 2'd0;
      end
    end
  end

  itf_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_beat && act_ok),
    .mag       (mag),
    .is_dec    (is_dec),
    .idle      (conv_idle),
    .res_valid (conv_done),
    .res_take  (take),
    .digits    (digits),
    .ndig      (ndig)
  );

  assign take     = conv_done && job_ready;
  assign ndig_eff = is_char_r ? 5'd0 : ndig;
  assign len      = {1'b0, ndig_eff} + {4'd0, pre_cnt_r};
  assign wsat     = width_r;

  always_comb begin
    job.pad     = (wsat > len) ? wsat - len : 6'd0;
    job.total   = (wsat > len) ? wsat : len;
    job.pre     = pre_r;
    job.pre_cnt = pre_cnt_r;
    job.fill    = fill_r;
    job.upper   = upper_r;
    job.digits  = digits;
  end

  itf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (conv_done),
    .job       (job),
    .job_ready (job_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

/* rtl/core/itf_conv.sv */
`default_nettype none
module itf_conv
  import itf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       mag,
  input  wire logic              is_dec,
  output logic                   idle,
  output logic                   res_valid,
  input  wire logic              res_take,
  output logic [4*NDEC-1:0]      digits,
  output logic [4:0]             ndig
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_DAB  = 4'b0010,
    C_NORM = 4'b0100,
    C_DONE = 4'b1000
  } conv_state_t;

  conv_state_t       state_r, state_nxt;
  logic [4*NDEC-1:0] dig_r, dig_nxt, adj;
  logic [63:0]       bin_r, bin_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [4:0]        ndig_r, ndig_nxt;

  // add three to every bcd digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? dig_r[4*i +: 4] + 4'd3
                                                : dig_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    bin_nxt   = bin_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    case (state_r)
      C_IDLE: begin
        if (start) begin
          if (is_dec) begin
            dig_nxt   = '0;
            bin_nxt   = mag;
            cnt_nxt   = 6'd63;
            state_nxt = C_DAB;
          end else begin
            dig_nxt   = {mag, {(4*(NDEC-NHEX)){1'b0}}};
            ndig_nxt  = 5'(NHEX);
            state_nxt = C_NORM;
          end
        end
      end
      C_DAB: begin
        {dig_nxt, bin_nxt} = {adj[4*NDEC-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          ndig_nxt  = 5'(NDEC);
          state_nxt = C_NORM;
        end
      end
      C_NORM: begin
        // drop leading zero digits, keeping at least one
        if (ndig_r > 5'd1 && dig_r[4*NDEC-1 -: 4] == 4'd0) begin
          dig_nxt  = {dig_r[4*NDEC-5:0], 4'd0};
          ndig_nxt = ndig_r - 5'd1;
        end else begin
          state_nxt = C_DONE;
        end
      end
      C_DONE: begin
        if (res_take) begin
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dig_r  <= dig_nxt;
    bin_r  <= bin_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
  end

  assign idle      = (state_r == C_IDLE);
  assign res_valid = (state_r == C_DONE);
  assign digits    = dig_r;
  assign ndig      = ndig_r;

endmodule
`default_nettype wire

/* rtl/core/itf_emit.sv */
`default_nettype none
module itf_emit
  import itf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     job_valid,
  input  wire itf_job_t job,
  output logic          job_ready,
  itf_out_if.source     out_ch
);

  logic [5:0]        rem_r, rem_nxt;
  logic [5:0]        pad_r, pad_nxt;
  logic [15:0]       pre_r, pre_nxt;
  logic [1:0]        pre_cnt_r, pre_cnt_nxt;
  logic [7:0]        fill_r, fill_nxt;
  logic              upper_r, upper_nxt;
  logic [4*NDEC-1:0] dig_r, dig_nxt;
  logic              ov_r, ov_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic              last_r, last_nxt;
  logic              step;

  assign job_ready = (rem_r == 6'd0);
  assign step      = (rem_r != 6'd0) && (!ov_r || out_ch.ready);

  always_comb begin
    rem_nxt     = rem_r;
    pad_nxt     = pad_r;
    pre_nxt     = pre_r;
    pre_cnt_nxt = pre_cnt_r;
    fill_nxt    = fill_r;
    upper_nxt   = upper_r;
    dig_nxt     = dig_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ch_nxt      = ch_r;
    last_nxt    = last_r;
    if (step) begin
      ov_nxt   = 1'b1;
      last_nxt = (rem_r == 6'd1);
      rem_nxt  = rem_r - 6'd1;
      if (pad_r != 6'd0) begin
        ch_nxt  = fill_r;
        pad_nxt = pad_r - 6'd1;
      end else if (pre_cnt_r != 2'd0) begin
        ch_nxt      = pre_r[15:8];
        pre_nxt     = {pre_r[7:0], 8'd0};
        pre_cnt_nxt = pre_cnt_r - 2'd1;
      end else begin
        ch_nxt  = dig2char(dig_r[4*NDEC-1 -: 4], upper_r);
        dig_nxt = {dig_r[4*NDEC-5:0], 4'd0};
      end
    end else if (job_valid && job_ready) begin
      rem_nxt     = job.total;
      pad_nxt     = job.pad;
      pre_nxt     = job.pre;
      pre_cnt_nxt = job.pre_cnt;
      fill_nxt    = job.fill;
      upper_nxt   = job.upper;
      dig_nxt     = job.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
    pad_r     <= pad_nxt;
    pre_r     <= pre_nxt;
    pre_cnt_r <= pre_cnt_nxt;
    fill_r    <= fill_nxt;
    upper_r   <= upper_nxt;
    dig_r     <= dig_nxt;
    ch_r      <= ch_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.char_out = ch_r;
  assign out_ch.last     = last_r;

endmodule
`default_nettype wire

/* rtl/core/itf_checker.sv */
`default_nettype none
module itf_checker
  import itf_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_action,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_last
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output beat changed while stalled");

  // a run never gaps once started
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a character run");

  // one item at a time in the converter
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action <= ACT_CHAR) |=> !in_ready)
    else $error("input taken while converting");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind integer_to_text_formatter_unit itf_checker u_itf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.char_out),
  .out_last  (out_ch.last)
);
`default_nettype wire

/* verif/integer_to_text_formatter_checker.sv */
module integer_to_text_formatter_checker
  import itf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  itf_in_if         in_ch,
  itf_out_if        out_ch,
  output int        fail_count,
  output int        pending_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] DIGITS_LO = "0123456789abcdef";
  localparam logic [127:0] DIGITS_UP = "0123456789ABCDEF";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  text_beat_t expected_text[$];

  function automatic void predict_text(input logic [2:0] act, input logic [63:0] val,
                                       input logic lng, input logic [5:0] fw,
                                       input logic zf);
    logic [7:0]  body [0:23];
    logic [7:0]  rev [0:23];
    logic [63:0] mag;
    logic [63:0] rem;
    logic [7:0]  fill;
    text_beat_t  beat;
    int len, nrev, pad, total, w, di, k;
    bit hex, upper;
    len = 0;
    nrev = 0;
    hex = 1'b0;
    upper = 1'b0;
    mag = 64'd0;
    case (act)
      ACT_UDEC: mag = lng ? val : {32'd0, val[31:0]};
      ACT_SDEC: begin
        mag = lng ? val : {{32{val[31]}}, val[31:0]};
        if (mag[63]) begin
          body[0] = CH_MINUS;
          len = 1;
          mag = 64'd0 - mag;
        end
      end
      ACT_HEXL, ACT_HEXU: begin
        hex = 1'b1;
        upper = (act == ACT_HEXU);
        mag = lng ? val : {32'd0, val[31:0]};
      end
      ACT_PTR: begin
        hex = 1'b1;
        mag = val;
        body[0] = CH_ZERO;
        body[1] = CH_X;
        len = 2;
      end
      ACT_CHAR: begin
        body[0] = val[7:0];
        len = 1;
      end
      default: return;
    endcase
    if (act != ACT_CHAR) begin
      do begin
        if (hex) begin
          di = int'(mag[3:0]);
        end else begin
          rem = mag % 64'd10;
          di = int'(rem[3:0]);
        end
        rev[nrev] = upper ? DIGITS_UP[8*(15-di) +: 8] : DIGITS_LO[8*(15-di) +: 8];
        nrev++;
        mag = hex ? (mag >> 4) : (mag / 64'd10);
      end while (mag != 64'd0);
      for (k = nrev - 1; k >= 0; k--) begin
        body[len] = rev[k];
        len++;
      end
    end
    w = (int'(fw) > MAX_WIDTH) ? MAX_WIDTH : int'(fw);
    pad = (w > len) ? w - len : 0;
    total = pad + len;
    fill = zf ? CH_ZERO : CH_SPACE;
    for (k = 0; k < total; k++) begin
      beat.ch = (k < pad) ? fill : body[k - pad];
      beat.last = (k == total - 1);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    int bad;
    bad = 0;
    if (!rst_n) begin
      expected_text.delete();
      fail_count <= 0;
      pending_beats <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("char_out: expected no beat, got %h", out_ch.char_out);
          bad++;
        end else begin
          want = expected_text.pop_front();
          if (out_ch.char_out !== want.ch) begin
            $error("char_out: expected %h, got %h", want.ch, out_ch.char_out);
            bad++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            bad++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_text(in_ch.action, in_ch.value, in_ch.is_long, in_ch.field_width,
                     in_ch.zero_fill);
      end
      fail_count <= fail_count + bad;
      pending_beats <= expected_text.size();
    end
  end

endmodule

/* verif/integer_to_text_formatter_unit_test.sv */
module integer_to_text_formatter_unit_test
  import itf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_BEAT   = 600;
  localparam int RANDOM_ITEMS    = 390;
  localparam int SETTLE_CYCLES   = 200;

  // kinds with no output text
  localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  bit   tx_calm;
  bit   rx_calm;

  itf_in_if  in_ch ();
  itf_out_if out_ch ();

  integer_to_text_formatter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  integer_to_text_formatter_checker text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (mismatches),
    .pending_beats (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic [2:0] act, input logic [63:0] val, input logic lng,
                           input logic [5:0] fw, input logic zf);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.value       <= val;
    in_ch.is_long     <= lng;
    in_ch.field_width <= fw;
    in_ch.zero_fill   <= zf;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [2:0]  act;
    logic [63:0] val;
    logic [5:0]  fw;
    int k;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_UDEC;
    in_ch.value       <= 64'd0;
    in_ch.is_long     <= 1'b0;
    in_ch.field_width <= 6'd0;
    in_ch.zero_fill   <= 1'b0;
    tx_calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ACT_UDEC, 64'd0, 1'b1, 6'd0, 1'b0);
    send_item(ACT_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 6'd0, 1'b0);
    send_item(ACT_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd12, 1'b1);
    send_item(ACT_SDEC, 64'h0000_0000_FFFF_FFFB, 1'b0, 6'd8, 1'b1);
    send_item(ACT_SDEC, 64'h0000_0000_FFFF_FFFB, 1'b0, 6'd8, 1'b0);
    send_item(ACT_SDEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, 1'b0);
    send_item(ACT_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 6'd21, 1'b1);
    send_item(ACT_SDEC, 64'hFFFF_FFFF_8000_0000, 1'b0, 6'd0, 1'b0);
    send_item(ACT_SDEC, 64'h1234_5678_7FFF_FFFF, 1'b0, 6'd1, 1'b1);
    send_item(ACT_SDEC, 64'd0, 1'b1, 6'd63, 1'b1);
    send_item(ACT_HEXL, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, 6'd0, 1'b0);
    send_item(ACT_HEXU, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, 6'd20, 1'b1);
    send_item(ACT_HEXL, 64'hFFFF_FFFF_0000_ABCD, 1'b0, 6'd8, 1'b1);
    send_item(ACT_HEXU, 64'd0, 1'b0, 6'd63, 1'b0);
    send_item(ACT_PTR, 64'd0, 1'b0, 6'd0, 1'b0);
    send_item(ACT_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd18, 1'b1);
    send_item(ACT_PTR, 64'h0000_0000_00C0_FFEE, 1'b1, 6'd63, 1'b0);
    send_item(ACT_CHAR, 64'hFFFF_FFFF_FFFF_FF41, 1'b1, 6'd0, 1'b0);
    send_item(ACT_CHAR, 64'd0, 1'b0, 6'd63, 1'b1);
    send_item(ACT_CHAR, 64'h0000_0000_0000_00FF, 1'b0, 6'd3, 1'b0);
    send_item(ACT_UNDEF_LO, 64'd12345, 1'b1, 6'd10, 1'b0);
    send_item(ACT_UNDEF_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 6'd63, 1'b1);
    send_item(ACT_UDEC, 64'd7, 1'b0, 6'd63, 1'b1);
    drain_results();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if (k == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 19) == 0) begin
        act = $urandom_range(0, 1) ? ACT_UNDEF_HI : ACT_UNDEF_LO;
      end else begin
        act = 3'($urandom_range(ACT_UDEC, ACT_CHAR));
      end
      val = {$urandom, $urandom};
      case ($urandom_range(0, 4))
        0: val = val >> $urandom_range(0, 63);
        1: val = 64'($urandom_range(0, 20));
        2: begin
          case ($urandom_range(0, 5))
            0: val = 64'd0;
            1: val = 64'hFFFF_FFFF_FFFF_FFFF;
            2: val = 64'h8000_0000_0000_0000;
            3: val = 64'h7FFF_FFFF_FFFF_FFFF;
            4: val = {$urandom, 32'h8000_0000};
            default: val = {$urandom, 32'hFFFF_FFFF};
          endcase
        end
        default: ;
      endcase
      fw = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(24, 63))
                                         : 6'($urandom_range(0, 24));
      send_item(act, val, 1'($urandom_range(0, 1)), fw, 1'($urandom_range(0, 1)));
    end
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side, with one long hold-off while the sender keeps offering
  initial begin
    int beats;
    int stall;
    out_ch.ready <= 1'b0;
    beats = 0;
    rx_calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (beats % 48 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (beats == HOLD_OFF_BEAT) begin
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      beats++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/itf_pkg.sv
rtl/core/itf_in_if.sv
rtl/core/itf_out_if.sv
rtl/core/itf_conv.sv
rtl/core/itf_emit.sv
rtl/core/integer_to_text_formatter_unit.sv
rtl/core/itf_checker.sv
verif/integer_to_text_formatter_checker.sv
verif/integer_to_text_formatter_unit_test.sv
